// ===== hw/rtl/lru_page_replacement_defines.svh =====
// Assertion macros used by lru_page_replacement.sv.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS
`define LRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/lru_pkg.sv =====
`timescale 1ns / 1ps

package lru_pkg;

    localparam int FRAMES_DEF = 16;
    localparam int FRAMES_MAX = 64;
    localparam int IDX_W      = $clog2(FRAMES_MAX);
    localparam int PAGE_W     = 16;
    localparam int AGE_W      = 16;
    localparam int FAULT_W    = 32;
    localparam int CFG_W      = 5;
    localparam int OUT_IDX_W  = 4;

    localparam logic [AGE_W-1:0]   AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [AGE_W-1:0]  age_t;

    typedef struct packed {
        logic  go;
        logic  found;
        idx_t  found_idx;
        logic  have_best;
        age_t  best_age;
        idx_t  best_idx;
        page_t best_page;
    } scan_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic load;
        idx_t slot;
    } upd_t;

endpackage

// ===== hw/rtl/lru_cell.sv =====
`timescale 1ns / 1ps

module lru_cell
    import lru_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    parameter int IDX    = 0,
    parameter int CW     = $clog2(FRAMES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  page_t         page,
    input  logic [CW-1:0] n_eff,
    input  upd_t          upd,
    input  scan_t         scan_in,
    output scan_t         scan_out
);

    page_t page_reg;
    age_t  age_reg;
    logic  valid_reg;
    scan_t scan_reg;
    scan_t scan_next;
    age_t  aged;
    logic  active;
    logic  is_slot;

    assign aged    = (age_reg == AGE_MAX) ? age_reg : age_reg + age_t'(1);
    assign active  = 32'(n_eff) > IDX;
    assign is_slot = upd.slot == idx_t'(IDX);

    always_comb
    begin
        scan_next = scan_in;
        if (!scan_in.found && valid_reg && page_reg == page)
        begin
            scan_next.found     = 1'b1;
            scan_next.found_idx = idx_t'(IDX);
        end
        if (active && (!scan_in.have_best || aged > scan_in.best_age))
        begin
            scan_next.have_best = 1'b1;
            scan_next.best_age  = aged;
            scan_next.best_idx  = idx_t'(IDX);
            scan_next.best_page = page_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg   <= '0;
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            scan_reg.go <= scan_in.go;
            if (scan_in.go)
            begin
                scan_reg.found     <= scan_next.found;
                scan_reg.found_idx <= scan_next.found_idx;
                scan_reg.have_best <= scan_next.have_best;
                scan_reg.best_age  <= scan_next.best_age;
                scan_reg.best_idx  <= scan_next.best_idx;
                scan_reg.best_page <= scan_next.best_page;
            end
            if (upd.en)
            begin
                if (valid_reg)
                begin
                    age_reg <= aged;
                end
                if (is_slot && upd.clr)
                begin
                    age_reg <= '0;
                end
                if (is_slot && upd.load)
                begin
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en && is_slot && upd.load)
        begin
            page_reg <= page;
        end
    end

    assign scan_out = scan_reg;

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
`include "lru_page_replacement_defines.svh"

// LRU page replacement with per-frame age counters.
// A page reference enters as an item on page_number with page_valid and
// page_ready. Each reference gives one result item on hit, frame_index,
// evicted_valid, evicted_page and fault_count with result_valid and
// result_ready. The frame count is written through cfg_data with cfg_valid
// and cfg_ready, which is always high; write it only while the block is idle.
// After acceptance a search pulse walks the row of frame cells, one cell per
// cycle, carrying the first matching frame and the oldest active frame.
// When it leaves the last cell the block moves to its commit state, where the
// table is updated and the result is registered. One item is in flight at a
// time; a new item is taken only once the last has been committed, and the
// row length of FRAMES cells sets how long a search takes.
// If the receiver stalls, the finished result holds and the next item is
// accepted and searched, but its update waits until the result is taken.
// Reset empties all frames, clears the ages and the fault count, and sets
// the frame count to 16.
module lru_page_replacement
    import lru_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 page_valid,
    output logic                 page_ready,
    input  logic [PAGE_W-1:0]    page_number,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 hit,
    output logic [OUT_IDX_W-1:0] frame_index,
    output logic                 evicted_valid,
    output logic [PAGE_W-1:0]    evicted_page,
    output logic [FAULT_W-1:0]   fault_count
);

    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CW-1:0]        filled_reg;
    logic [FAULT_W-1:0]   fault_reg;
    logic [FAULT_W-1:0]   fault_next;
    page_t                page_reg;
    logic                 start_reg;
    logic                 result_valid_reg;
    logic                 hit_reg;
    logic [OUT_IDX_W-1:0] frame_index_reg;
    logic                 evicted_valid_reg;
    page_t                evicted_page_reg;
    logic [CW-1:0]        n_eff;
    logic                 commit;
    logic                 do_fill;
    upd_t                 upd;
    scan_t                chain [FRAMES+1];

    assign cfg_ready     = 1'b1;
    assign page_ready    = state_reg == ST_IDLE;
    assign result_valid  = result_valid_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = fault_reg;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(cfg_reg) > FRAMES)
        begin
            n_eff = CW'(FRAMES);
        end
        else
        begin
            n_eff = CW'(cfg_reg);
        end
    end

    always_comb
    begin
        chain[0]    = '0;
        chain[0].go = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++)
        begin : g_cell
            lru_cell #(
                .FRAMES (FRAMES),
                .IDX    (gi),
                .CW     (CW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .page     (page_reg),
                .n_eff    (n_eff),
                .upd      (upd),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1])
            );
        end
    endgenerate

    assign commit  = (state_reg == ST_COMMIT) && (!result_valid_reg || result_ready);
    assign do_fill = !chain[FRAMES].found && (filled_reg < n_eff);

    always_comb
    begin
        upd.en   = commit;
        upd.clr  = 1'b1;
        upd.load = !chain[FRAMES].found;
        if (chain[FRAMES].found)
        begin
            upd.slot = chain[FRAMES].found_idx;
        end
        else if (do_fill)
        begin
            upd.slot = idx_t'(filled_reg);
        end
        else
        begin
            upd.slot = chain[FRAMES].best_idx;
        end
    end

    assign fault_next = (fault_reg == FAULT_MAX) ? fault_reg : fault_reg + FAULT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (page_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain[FRAMES].go)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cfg_reg          <= CFG_RESET;
            filled_reg       <= '0;
            fault_reg        <= '0;
            start_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= page_valid && page_ready;
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (commit)
            begin
                result_valid_reg <= 1'b1;
                if (!chain[FRAMES].found)
                begin
                    fault_reg <= fault_next;
                end
                if (do_fill)
                begin
                    filled_reg <= filled_reg + CW'(1);
                end
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (page_valid && page_ready)
        begin
            page_reg <= page_number;
        end
        if (commit)
        begin
            hit_reg           <= chain[FRAMES].found;
            frame_index_reg   <= OUT_IDX_W'(upd.slot);
            evicted_valid_reg <= !chain[FRAMES].found && !do_fill;
            evicted_page_reg  <= (!chain[FRAMES].found && !do_fill) ?
                                 chain[FRAMES].best_page : '0;
        end
    end

    `LRU_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, page_valid && page_ready, state_reg == ST_SCAN)
    `LRU_ASSERT_IMPL(a_slot_in_range, clk, rst_n, commit && !chain[FRAMES].found, 32'(upd.slot) < 32'(n_eff))
    `LRU_ASSERT_NEXT(a_fault_monotonic, clk, rst_n, 1'b1, fault_reg >= $past(fault_reg))
    `LRU_ASSERT_IMPL(a_filled_bounded, clk, rst_n, 1'b1, 32'(filled_reg) <= FRAMES)

endmodule
